FILE: rtl/core/imuwma_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helper functions for the imu weighted moving average
package imuwma_pkg;

   localparam int WINDOW_LEN_DEF = 7;
   localparam int NUM_AXES       = 6;
   localparam int AXIS_W         = 16;
   localparam int SAMPLE_W       = NUM_AXES * AXIS_W;
   localparam int OP_W           = 2;
   localparam int DEADBAND_W     = 15;

   localparam logic [DEADBAND_W-1:0] DEADBAND_RESET = 15'd143;

   // first rate axis inside a sample
   localparam int RATE_AXIS_0 = 3;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH  = 2'd0,
      OP_PEEK  = 2'd1,
      OP_CLEAR = 2'd2
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_RD,
      ST_ACC,
      ST_DIVLD,
      ST_DIV,
      ST_OUT
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic load_in;
      logic acc_init;
      logic acc_step;
      logic div_load;
      logic div_step;
      logic ram_re;
      logic ram_we;
      logic load_out;
      logic filt;
      logic apply_db;
   } cmd_type;

   // sum of weights 1..n
   function automatic int weight_sum(input int n);
      return n * (n + 1) / 2;
   endfunction

   // bits for the magnitude of the weighted sum of 16-bit samples
   function automatic int mag_width(input int n);
      return 15 + $clog2(weight_sum(n) + 1);
   endfunction

endpackage

FILE: rtl/core/imu_weighted_moving_average.sv
`timescale 1ns / 1ps
// top level of the seven-tap linearly weighted moving average for six-axis imu samples
//
//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+----------------------------------------------
//  req     | in  | req_tvalid / req_tready | tdata: 6 x 16 b sample, tuser: opcode
//  rsp     | out | rsp_tvalid / rsp_tready | tdata: 6 x 16 b result, tuser: smoothed
//  csr     | in  | csr_we                  | csr_wdata: rate deadband, Q3.12
//
//  a pass-through transaction runs idle, decode and result; a clear or unused opcode runs
//    idle and decode only; a filtered one adds one window ram read and one accumulate per
//    tap, then magnitude, reciprocal divide and result load
//  reset (synchronous): window empty, deadband 143; window ram is not cleared, an
//    entry is always written before it is read
//  the result register parts the two sides: a new transaction is taken while the previous
//    result waits; a finished result waits in the controller until the register is free
module imu_weighted_moving_average #(
   parameter int WINDOW_LEN = imuwma_pkg::WINDOW_LEN_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // input transaction
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z (16 b each, lowest first)
   input  logic [imuwma_pkg::SAMPLE_W-1:0]   req_tdata,
   // opcode: 0 push, 1 peek, 2 clear
   input  logic [imuwma_pkg::OP_W-1:0]       req_tuser,
   // result transaction
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // out_accel_x, out_accel_y, out_accel_z, out_rate_x, out_rate_y, out_rate_z
   output logic [imuwma_pkg::SAMPLE_W-1:0]   rsp_tdata,
   // smoothed
   output logic                              rsp_tuser,
   // rate deadband register
   input  logic                              csr_we,
   input  logic [imuwma_pkg::DEADBAND_W-1:0] csr_wdata
);
   import imuwma_pkg::*;

   localparam int AW = $clog2(WINDOW_LEN);

   cmd_type       cmd;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] tap;

   // sequencing, fill count, window head, result valid
   imuwma_ctrl #(
      .WINDOW_LEN (WINDOW_LEN)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .wr_addr    (wr_addr),
      .rd_addr    (rd_addr),
      .tap        (tap)
   );

   // window ram, accumulators, divider, deadband and result payload
   imuwma_dp #(
      .WINDOW_LEN (WINDOW_LEN)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .wr_addr   (wr_addr),
      .rd_addr   (rd_addr),
      .tap       (tap),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

FILE: rtl/core/imuwma_ram.sv
`timescale 1ns / 1ps
// generic one-write one-read ram with registered read data
module imuwma_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/imuwma_ctrl.sv
`timescale 1ns / 1ps
// controller: sequencing, window bookkeeping and result handshake
module imuwma_ctrl #(
   parameter int WINDOW_LEN = 7
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [imuwma_pkg::OP_W-1:0]   req_op,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output imuwma_pkg::cmd_type           cmd,
   output logic [$clog2(WINDOW_LEN)-1:0] wr_addr,
   output logic [$clog2(WINDOW_LEN)-1:0] rd_addr,
   output logic [$clog2(WINDOW_LEN)-1:0] tap
);
   import imuwma_pkg::*;

   localparam int AW    = $clog2(WINDOW_LEN);
   localparam int FW    = $clog2(WINDOW_LEN + 1);

   localparam logic [AW-1:0] LAST_IDX  = AW'(WINDOW_LEN - 1);
   localparam logic [FW-1:0] FULL_CNT  = FW'(WINDOW_LEN);

   state_type       state_ff, state_in;
   logic [OP_W-1:0] op_ff, op_in;
   logic [FW-1:0]   fill_ff, fill_in;
   logic [AW-1:0]   head_ff, head_in;
   logic [AW-1:0]   ptr_ff, ptr_in;
   logic [AW-1:0]   tap_ff, tap_in;
   logic            filt_ff, filt_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            full;
   logic            out_free;

   function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] p);
      return (p == LAST_IDX) ? '0 : p + AW'(1);
   endfunction

   assign full     = (fill_ff == FULL_CNT);
   assign out_free = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            unique case (op_ff) inside
               OP_PUSH, OP_PEEK: state_in = full ? ST_RD : ST_OUT;
               default:          state_in = ST_IDLE;
            endcase
         end
         ST_RD:    state_in = ST_ACC;
         ST_ACC:   state_in = (tap_ff == LAST_IDX) ? ST_DIVLD : ST_RD;
         ST_DIVLD: state_in = ST_DIV;
         ST_DIV:   state_in = ST_OUT;
         ST_OUT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd          = '0;
      cmd.filt     = filt_ff;
      cmd.apply_db = (op_ff == OP_PUSH);
      req_tready   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.load_in = req_tvalid;
         end
         ST_DECODE: cmd.acc_init = 1'b1;
         ST_RD:     cmd.ram_re   = 1'b1;
         ST_ACC:    cmd.acc_step = 1'b1;
         ST_DIVLD:  cmd.div_load = 1'b1;
         ST_DIV:    cmd.div_step = 1'b1;
         ST_OUT: begin
            cmd.load_out = out_free;
            cmd.ram_we   = out_free && (op_ff == OP_PUSH);
         end
         default: ;
      endcase
   end

   assign wr_addr    = filt_ff ? head_ff : fill_ff[AW-1:0];
   assign rd_addr    = ptr_ff;
   assign tap        = tap_ff;
   assign rsp_tvalid = rsp_valid_ff;

   // window pointers, counters and result valid
   always_comb begin
      op_in        = op_ff;
      fill_in      = fill_ff;
      head_in      = head_ff;
      ptr_in       = ptr_ff;
      tap_in       = tap_ff;
      filt_in      = filt_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) rsp_valid_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) op_in = req_op;
         end
         ST_DECODE: begin
            filt_in = full;
            ptr_in  = next_idx(head_ff);
            tap_in  = AW'(1);
            if (op_ff == OP_CLEAR) begin
               fill_in = '0;
               head_in = '0;
            end
         end
         ST_ACC: begin
            tap_in = tap_ff + AW'(1);
            ptr_in = next_idx(ptr_ff);
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (op_ff == OP_PUSH) begin
                  if (filt_ff) head_in = next_idx(head_ff);
                  else         fill_in = fill_ff + FW'(1);
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         filt_ff      <= 1'b0;
         op_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
         filt_ff      <= filt_in;
         op_ff        <= op_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      tap_ff <= tap_in;
   end

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FULL_CNT)
      else $error("window count beyond window length");

   a_head_full: assert property (@(posedge clock) disable iff (reset)
      head_ff != '0 |-> full)
      else $error("window head moved before the window was full");

   a_read_full: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RD |-> full && tap_ff != '0)
      else $error("tap read with a partial window or the oldest tap");

   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> !rsp_valid_ff || rsp_tready)
      else $error("result register overwritten before it was taken");

endmodule

FILE: rtl/core/imuwma_dp.sv
`timescale 1ns / 1ps
// datapath: sample window ram, weighted accumulators, reciprocal divider, result register
module imuwma_dp #(
   parameter int WINDOW_LEN = 7
) (
   input  logic                                clock,
   input  logic                                reset,
   input  imuwma_pkg::cmd_type                 cmd,
   input  logic [$clog2(WINDOW_LEN)-1:0]       wr_addr,
   input  logic [$clog2(WINDOW_LEN)-1:0]       rd_addr,
   input  logic [$clog2(WINDOW_LEN)-1:0]       tap,
   input  logic                                csr_we,
   input  logic [imuwma_pkg::DEADBAND_W-1:0]   csr_wdata,
   input  logic [imuwma_pkg::SAMPLE_W-1:0]     req_tdata,
   output logic [imuwma_pkg::SAMPLE_W-1:0]     rsp_tdata,
   output logic                                rsp_tuser
);
   import imuwma_pkg::*;

   localparam int TW       = $clog2(WINDOW_LEN);
   localparam int WSUM     = weight_sum(WINDOW_LEN);
   localparam int MAG_W    = mag_width(WINDOW_LEN);
   localparam int ACC_W    = MAG_W + 1;
   localparam int RW       = $clog2(WSUM);
   localparam int NW       = $clog2(WINDOW_LEN + 1) + 1;
   localparam int PI_W     = AXIS_W + NW;
   localparam int PT_W     = AXIS_W + TW + 1;
   // reciprocal of the weight sum, exact for every magnitude below 2**MAG_W
   localparam int RECIP_SH = MAG_W + RW;
   localparam int M_W      = MAG_W + 2;
   localparam int PROD_W   = MAG_W + M_W;
   localparam longint RECIP_L =
      ((longint'(1) << RECIP_SH) + longint'(WSUM) - longint'(1)) / longint'(WSUM);

   localparam logic signed [NW-1:0] NEWEST_WT = NW'(WINDOW_LEN);
   localparam logic [M_W-1:0]       RECIP     = M_W'(RECIP_L);

   logic [SAMPLE_W-1:0]          in_ff;
   logic [SAMPLE_W-1:0]          rd_data;
   logic [DEADBAND_W-1:0]        db_ff;
   logic signed [ACC_W-1:0]      acc_ff  [NUM_AXES];
   logic signed [ACC_W-1:0]      acc_in  [NUM_AXES];
   logic [MAG_W-1:0]             mag_ff  [NUM_AXES];
   logic [MAG_W-1:0]             mag_in  [NUM_AXES];
   logic [NUM_AXES-1:0]          neg_ff, neg_in;
   logic [SAMPLE_W-1:0]          filt_res;
   logic [SAMPLE_W-1:0]          out_data_ff;
   logic                         out_filt_ff;

   imuwma_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (WINDOW_LEN)
   ) u_window (
      .clock   (clock),
      .wr_en   (cmd.ram_we),
      .wr_addr (wr_addr),
      .wr_data (in_ff),
      .rd_en   (cmd.ram_re),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // weighted sum, one window tap per step, all axes side by side
   always_comb begin
      logic signed [AXIS_W-1:0] fresh;
      logic signed [AXIS_W-1:0] stored;
      logic signed [PI_W-1:0]   prod_init;
      logic signed [PT_W-1:0]   prod_tap;
      for (int a = 0; a < NUM_AXES; a++) begin
         fresh     = in_ff[a*AXIS_W +: AXIS_W];
         stored    = rd_data[a*AXIS_W +: AXIS_W];
         prod_init = fresh * NEWEST_WT;
         prod_tap  = stored * $signed({1'b0, tap});
         if (cmd.acc_init)      acc_in[a] = ACC_W'(prod_init);
         else if (cmd.acc_step) acc_in[a] = acc_ff[a] + ACC_W'(prod_tap);
         else                   acc_in[a] = acc_ff[a];
      end
   end

   // magnitude and sign, then divide by the weight sum with one reciprocal multiply
   always_comb begin
      logic [PROD_W-1:0] prod;
      for (int a = 0; a < NUM_AXES; a++) begin
         prod      = PROD_W'(mag_ff[a]) * PROD_W'(RECIP);
         mag_in[a] = mag_ff[a];
         neg_in[a] = neg_ff[a];
         if (cmd.div_load) begin
            neg_in[a] = acc_ff[a][ACC_W-1];
            mag_in[a] = acc_ff[a][ACC_W-1] ? MAG_W'(-acc_ff[a]) : MAG_W'(acc_ff[a]);
         end else if (cmd.div_step) begin
            mag_in[a] = MAG_W'(prod >> RECIP_SH);
         end
      end
   end

   // sign restore and, on a push, rate deadband
   always_comb begin
      logic [AXIS_W-1:0] q;
      logic              in_band;
      for (int a = 0; a < NUM_AXES; a++) begin
         q       = mag_ff[a][AXIS_W-1:0];
         in_band = (mag_ff[a] < MAG_W'(db_ff));
         if (a >= RATE_AXIS_0 && cmd.apply_db && in_band) begin
            filt_res[a*AXIS_W +: AXIS_W] = '0;
         end else begin
            filt_res[a*AXIS_W +: AXIS_W] = neg_ff[a] ? (AXIS_W'(0) - q) : q;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         db_ff <= DEADBAND_RESET;
      end else if (csr_we) begin
         db_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) in_ff <= req_tdata;
      for (int a = 0; a < NUM_AXES; a++) begin
         acc_ff[a] <= acc_in[a];
         mag_ff[a] <= mag_in[a];
      end
      neg_ff <= neg_in;
      if (cmd.load_out) begin
         out_data_ff <= cmd.filt ? filt_res : in_ff;
         out_filt_ff <= cmd.filt;
      end
   end

   assign rsp_tdata = out_data_ff;
   assign rsp_tuser = out_filt_ff;

endmodule
